FILE: rtl/ple_pkg.sv
// Package for the positional list engine.
// Holds the command, status, cell-action and state codes and the cell control struct.
// No dependencies.
package ple_pkg;

    localparam int POS_W = 6;
    localparam int LEN_W = 7;
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_INDEX = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_END   = 3'd4,
        CMD_DEL_INDEX = 3'd5,
        CMD_UPDATE    = 3'd6,
        CMD_DUMP      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_UPDATE,
        CELL_ROTATE
    } cell_action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESULT,
        S_DUMP
    } state_t;

    typedef struct packed {
        cell_action_t             action;
        logic [LEN_W-1:0]         pos;
        logic [LEN_W-1:0]         tail;
        logic signed [VAL_W-1:0]  value;
    } cell_ctrl_t;

endpackage

FILE: rtl/ple_cell.sv
// One storage cell of the positional list.
// Depends on ple_pkg for the cell control struct and action codes.
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  ple_pkg::cell_ctrl_t               ctrl,
    input  logic signed [ple_pkg::VAL_W-1:0]  left_data,
    input  logic signed [ple_pkg::VAL_W-1:0]  right_data,
    input  logic signed [ple_pkg::VAL_W-1:0]  head_data,
    output logic signed [ple_pkg::VAL_W-1:0]  data
);

    localparam logic [ple_pkg::LEN_W-1:0] MY_IDX = IDX[ple_pkg::LEN_W-1:0];

    logic signed [ple_pkg::VAL_W-1:0] data_reg;
    logic signed [ple_pkg::VAL_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.action)
            ple_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            ple_pkg::CELL_INSERT:
            begin
                if (MY_IDX == ctrl.pos)
                begin
                    data_next = ctrl.value;
                end
                else if (MY_IDX > ctrl.pos)
                begin
                    data_next = left_data;
                end
            end
            ple_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= ctrl.pos)
                begin
                    data_next = right_data;
                end
            end
            ple_pkg::CELL_UPDATE:
            begin
                if (MY_IDX == ctrl.pos)
                begin
                    data_next = ctrl.value;
                end
            end
            ple_pkg::CELL_ROTATE:
            begin
                if (MY_IDX == ctrl.tail)
                begin
                    data_next = head_data;
                end
                else if (MY_IDX < ctrl.tail)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/positional_list_engine.sv
// Top level of the positional list engine: command decode, count and result register.
// Depends on ple_pkg and ple_cell.
//
// An ordered list of up to CAPACITY signed 32-bit values held in a row of cells, slot 0 at the
// front. Every command except dump is one input transaction, then the single
// result transaction, since one command is handled at a time and the result sits in one output
// register. Inserts and deletes shift all cells behind the position in the accept cycle. A dump
// of N elements gives N result transactions: the cell row rotates by one slot per result
// transaction, bringing each element to the front cell in turn and back to its place after
// the last. A dump of an empty list gives one result with has_value low. Slots that were never
// written come up undefined; no command reads them.
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cmd[2:0], position[8:3], value[40:9], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_value[31:0], length[38:32], zero fill
    output logic [2:0]  m_tuser,   // status[1:0], has_value[2]
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LW    = ple_pkg::LEN_W;
    localparam int VW    = ple_pkg::VAL_W;

    ple_pkg::state_t        state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       remain_reg, remain_next;
    ple_pkg::status_t       status_reg, status_next;
    logic                   has_value_reg, has_value_next;
    logic signed [VW-1:0]   read_value_reg, read_value_next;
    logic                   last_reg, last_next;
    logic [LW-1:0]          length_reg, length_next;

    ple_pkg::cell_ctrl_t    ctrl;
    logic signed [VW-1:0]   cell_q [CAPACITY];

    ple_pkg::cmd_t          in_cmd;
    logic [LW-1:0]          in_pos;
    logic signed [VW-1:0]   in_value;
    logic [LW-1:0]          cnt_ext;
    logic [LW-1:0]          ins_pos;

    assign in_cmd   = ple_pkg::cmd_t'(s_tdata[2:0]);
    assign in_pos   = LW'(s_tdata[8:3]);
    assign in_value = s_tdata[40:9];
    assign cnt_ext  = LW'(cnt_reg);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VW-1:0] left_d;
            logic signed [VW-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = ctrl.value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_d = cell_q[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end
            ple_cell #(
                .IDX(gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .left_data (left_d),
                .right_data(right_d),
                .head_data (cell_q[0]),
                .data      (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        ins_pos = in_pos;
        unique case (in_cmd)
            ple_pkg::CMD_INS_FRONT: ins_pos = '0;
            ple_pkg::CMD_INS_END:   ins_pos = cnt_ext;
            default:                ins_pos = in_pos;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        remain_next     = remain_reg;
        status_next     = status_reg;
        has_value_next  = has_value_reg;
        read_value_next = read_value_reg;
        last_next       = last_reg;
        length_next     = length_reg;
        ctrl.action     = ple_pkg::CELL_HOLD;
        ctrl.pos        = in_pos;
        ctrl.tail       = cnt_ext - 1'b1;
        ctrl.value      = in_value;

        unique case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    status_next     = ple_pkg::ST_OK;
                    has_value_next  = 1'b0;
                    read_value_next = '0;
                    last_next       = 1'b1;
                    state_next      = ple_pkg::S_RESULT;
                    unique case (in_cmd)
                        ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_END,
                        ple_pkg::CMD_INS_INDEX:
                        begin
                            ctrl.pos = ins_pos;
                            if (ins_pos > cnt_ext)
                            begin
                                status_next = ple_pkg::ST_BOUND;
                            end
                            else if (cnt_ext >= LW'(CAPACITY))
                            begin
                                status_next = ple_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.action = ple_pkg::CELL_INSERT;
                                cnt_next    = CNT_W'(cnt_reg + 1'b1);
                            end
                        end
                        ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_END:
                        begin
                            ctrl.pos = (in_cmd == ple_pkg::CMD_DEL_FRONT) ? '0
                                                                          : cnt_ext - 1'b1;
                            if (cnt_reg == '0)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.action = ple_pkg::CELL_DELETE;
                                cnt_next    = cnt_reg - 1'b1;
                            end
                        end
                        ple_pkg::CMD_DEL_INDEX:
                        begin
                            if (in_pos >= cnt_ext)
                            begin
                                status_next = ple_pkg::ST_BOUND;
                            end
                            else
                            begin
                                ctrl.action = ple_pkg::CELL_DELETE;
                                cnt_next    = cnt_reg - 1'b1;
                            end
                        end
                        ple_pkg::CMD_UPDATE:
                        begin
                            if (in_pos >= cnt_ext)
                            begin
                                status_next = ple_pkg::ST_BOUND;
                            end
                            else
                            begin
                                ctrl.action = ple_pkg::CELL_UPDATE;
                            end
                        end
                        ple_pkg::CMD_DUMP:
                        begin
                            if (cnt_reg != '0)
                            begin
                                ctrl.action     = ple_pkg::CELL_ROTATE;
                                has_value_next  = 1'b1;
                                read_value_next = cell_q[0];
                                last_next       = (cnt_reg == CNT_W'(1));
                                remain_next     = cnt_reg - 1'b1;
                                state_next      = ple_pkg::S_DUMP;
                            end
                        end
                        default:
                        begin
                            status_next = ple_pkg::ST_OK;
                        end
                    endcase
                    length_next = LW'(cnt_next);
                end
            end
            ple_pkg::S_RESULT:
            begin
                if (m_tready)
                begin
                    state_next = ple_pkg::S_IDLE;
                end
            end
            ple_pkg::S_DUMP:
            begin
                if (m_tready)
                begin
                    if (last_reg)
                    begin
                        state_next = ple_pkg::S_IDLE;
                    end
                    else
                    begin
                        ctrl.action     = ple_pkg::CELL_ROTATE;
                        read_value_next = cell_q[0];
                        last_next       = (remain_reg == CNT_W'(1));
                        remain_next     = remain_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ple_pkg::S_IDLE;
            cnt_reg    <= '0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        has_value_reg  <= has_value_next;
        read_value_reg <= read_value_next;
        last_reg       <= last_next;
        length_reg     <= length_next;
    end

    assign s_tready = (state_reg == ple_pkg::S_IDLE);
    assign m_tvalid = (state_reg != ple_pkg::S_IDLE);
    assign m_tdata  = {1'b0, length_reg, read_value_reg};
    assign m_tuser  = {has_value_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: rtl/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on positional_list_engine port names and its CAPACITY parameter.
module ple_checker #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tdata[31:0] == 32'd0 && m_tlast)
        else $error("result without value must be zero and last");

    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'd0 && m_tdata[38:32] != 7'd0)
        else $error("dumped element with bad status or length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[38:32] <= 7'(CAPACITY))
        else $error("length above capacity");

endmodule

bind positional_list_engine ple_checker #(
    .CAPACITY(CAPACITY)
) u_ple_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
